### hw/rtl/bclp_pkg.sv
package bclp_pkg;

  localparam int unsigned LEVEL_BITS  = 8;
  localparam int unsigned BTN_IDX_W   = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [LIMIT_W-1:0]   LONG_RESET  = 16'd3000;
  localparam logic [LIMIT_W-1:0]   SHORT_RESET = 16'd300;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_LONG    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT   = 1'b1;

  localparam logic ACT_SHORT = 1'b0;
  localparam logic ACT_LONG  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]     now_ms;
    logic [LEVEL_BITS-1:0] levels;
  } in_item_t;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] button_index;
    logic                 action;
    logic [COUNT_W-1:0]   press_count;
    logic                 last_event;
  } out_item_t;

  typedef struct packed {
    logic               last_level;
    logic               active;
    logic [TIME_W-1:0]  change_time;
    logic [COUNT_W-1:0] press_counter;
  } btn_entry_t;

  localparam btn_entry_t ENTRY_RESET = '{
    last_level:    1'b1,
    active:        1'b0,
    change_time:   '0,
    press_counter: '0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

endpackage

### hw/rtl/bclp_stream_if.sv
interface bclp_in_if;
  logic               valid;
  logic               ready;
  bclp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bclp_out_if;
  logic                valid;
  logic                ready;
  bclp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/button_click_long_press_classifier.sv
// channel   role    payload
// in_ch     sink    now_ms[31:0], levels[7:0]
// out_ch    source  button_index[2:0], action, press_count[7:0], last_event
// cfg       write   cfg_we, cfg_index[0] (0 long, 1 short), cfg_data[15:0]
//
// After a tick is accepted, in_ch.ready stays low while N buttons are swept,
// N = min(NUM_BUTTONS, 8): per button a state memory read state and an
// evaluate/write-back state, then a flush state for the final event.
// Events are held one deep so the last of a tick can be marked; a stalled
// out_ch holds the sweep in its evaluate or flush cycle. Synchronous reset
// returns all buttons to idle via per-entry valid bits and restores the limits.
module button_click_long_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  bclp_in_if.sink                            in_ch,
  bclp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bclp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bclp_pkg::LIMIT_W-1:0]       cfg_data
);

  localparam int unsigned NUSED = (NUM_BUTTONS < bclp_pkg::LEVEL_BITS) ?
                                  NUM_BUTTONS : bclp_pkg::LEVEL_BITS;
  localparam int unsigned IW    = (NUSED > 1) ? $clog2(NUSED) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUSED - 1);

  bclp_pkg::state_t state, state_next;

  logic [bclp_pkg::LIMIT_W-1:0]  long_lim, short_lim;
  logic [bclp_pkg::TIME_W-1:0]   now_q;
  logic [bclp_pkg::LEVEL_BITS-1:0] levels_q;
  logic [IW-1:0]                 idx;

  bclp_pkg::btn_entry_t mem [NUSED];
  bclp_pkg::btn_entry_t mem_q;
  logic [NUSED-1:0]     entry_valid;
  logic                 mem_q_valid;

  logic                 out_valid;
  bclp_pkg::out_item_t  out_q;
  logic                 pend_valid;
  bclp_pkg::out_item_t  pend_q;

  bclp_pkg::btn_entry_t cur, upd;
  bclp_pkg::out_item_t  evt, out_item;
  logic [bclp_pkg::TIME_W-1:0] elapsed;
  logic level, fire, fire_act, out_free;
  logic mem_rd, mem_wr, out_load, pend_set, pend_clr, idx_inc;

  assign in_ch.ready    = (state == bclp_pkg::ST_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_q;
  assign out_free       = !out_valid || out_ch.ready;

  // evaluate one button
  always_comb begin
    cur      = mem_q_valid ? mem_q : bclp_pkg::ENTRY_RESET;
    upd      = cur;
    level    = levels_q[idx];
    elapsed  = now_q - cur.change_time;
    fire     = 1'b0;
    fire_act = bclp_pkg::ACT_SHORT;
    if (level != cur.last_level) begin
      if (!(!cur.last_level && !cur.active)) begin
        upd.change_time = now_q;
        upd.active      = 1'b1;
        if (!level && cur.press_counter != bclp_pkg::COUNT_MAX) begin
          upd.press_counter = cur.press_counter + 1'b1;
        end
      end
      upd.last_level = level;
    end else if (cur.active) begin
      if (!level) begin
        fire     = elapsed > {{(bclp_pkg::TIME_W-bclp_pkg::LIMIT_W){1'b0}}, long_lim};
        fire_act = bclp_pkg::ACT_LONG;
      end else begin
        fire     = elapsed > {{(bclp_pkg::TIME_W-bclp_pkg::LIMIT_W){1'b0}}, short_lim};
        fire_act = bclp_pkg::ACT_SHORT;
      end
      if (fire) begin
        upd.press_counter = '0;
        upd.active        = 1'b0;
      end
    end
    evt.button_index = bclp_pkg::BTN_IDX_W'(idx);
    evt.action       = fire_act;
    evt.press_count  = cur.press_counter;
    evt.last_event   = 1'b0;
  end

  always_comb begin
    state_next = state;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    out_load   = 1'b0;
    out_item   = pend_q;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    idx_inc    = 1'b0;
    unique case (state)
      bclp_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = bclp_pkg::ST_READ;
      end
      bclp_pkg::ST_READ: begin
        mem_rd     = 1'b1;
        state_next = bclp_pkg::ST_EVAL;
      end
      bclp_pkg::ST_EVAL: begin
        if (!fire || !pend_valid || out_free) begin
          mem_wr = 1'b1;
          if (fire) begin
            pend_set = 1'b1;
            if (pend_valid) begin
              out_load            = 1'b1;
              out_item.last_event = 1'b0;
            end
          end
          if (idx == LAST_IDX) begin
            state_next = bclp_pkg::ST_FLUSH;
          end else begin
            idx_inc    = 1'b1;
            state_next = bclp_pkg::ST_READ;
          end
        end
      end
      bclp_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = bclp_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load            = 1'b1;
          out_item.last_event = 1'b1;
          pend_clr            = 1'b1;
          state_next          = bclp_pkg::ST_IDLE;
        end
      end
      default: state_next = bclp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bclp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_lim  <= bclp_pkg::LONG_RESET;
      short_lim <= bclp_pkg::SHORT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bclp_pkg::REG_LONG:  long_lim  <= cfg_data;
        bclp_pkg::REG_SHORT: short_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      now_q    <= in_ch.payload.now_ms;
      levels_q <= in_ch.payload.levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      idx <= '0;
    end else if (idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // state memory
  always_ff @(posedge clk) begin
    if (mem_wr) mem[idx] <= upd;
    if (mem_rd) mem_q <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      mem_q_valid <= 1'b0;
    end else begin
      if (mem_wr) entry_valid[idx] <= 1'b1;
      if (mem_rd) mem_q_valid <= entry_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_set) begin
      pend_valid <= 1'b1;
    end else if (pend_clr) begin
      pend_valid <= 1'b0;
    end
    if (pend_set) pend_q <= evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) out_q <= out_item;
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ch.ready))
    else $error("output register overwritten before transaction");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == bclp_pkg::ST_IDLE) |-> !pend_valid)
    else $error("pending event left behind at end of tick");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == bclp_pkg::ST_READ && idx == '0))
    else $error("sweep did not start at first button");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == bclp_pkg::ST_FLUSH) |-> out_item.last_event)
    else $error("final event of tick not marked");

  a_eval_last_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == bclp_pkg::ST_EVAL) |-> !out_item.last_event)
    else $error("intermediate event marked as last");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           tick_valid = 1'b0;
  bclp_pkg::in_item_t             tick_data  = '0;
  logic                           event_ready = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [bclp_pkg::CFG_IDX_W-1:0] cfg_index = bclp_pkg::REG_LONG;
  logic [bclp_pkg::LIMIT_W-1:0]   cfg_data  = '0;

  bclp_in_if  tick_if();
  bclp_out_if event_if();

  assign tick_if.valid    = tick_valid;
  assign tick_if.payload  = tick_data;
  assign event_if.ready   = event_ready;

  button_click_long_press_classifier #(.NUM_BUTTONS(8)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (tick_if),
    .out_ch    (event_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predicted button state
  logic [bclp_pkg::LIMIT_W-1:0]    long_limit;
  logic [bclp_pkg::LIMIT_W-1:0]    short_limit;
  logic [bclp_pkg::LEVEL_BITS-1:0] btn_level;
  logic [bclp_pkg::LEVEL_BITS-1:0] btn_active;
  logic [bclp_pkg::TIME_W-1:0]     btn_stamp   [bclp_pkg::LEVEL_BITS];
  logic [bclp_pkg::COUNT_W-1:0]    btn_presses [bclp_pkg::LEVEL_BITS];

  bclp_pkg::in_item_t  pending_ticks[$];
  bclp_pkg::out_item_t due_events[$];
  int ticks_queued   = 0;
  int ticks_accepted = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic [bclp_pkg::TIME_W-1:0]     gen_now    = '0;
  logic [bclp_pkg::LEVEL_BITS-1:0] gen_levels = '1;

  function automatic void classify_tick(bclp_pkg::in_item_t t);
    bclp_pkg::out_item_t         held_ev;
    bit                          have_ev;
    logic                        lvl;
    logic [bclp_pkg::TIME_W-1:0] held;
    bit                          fire;
    have_ev = 0;
    held_ev = '0;
    for (int i = 0; i < bclp_pkg::LEVEL_BITS; i++) begin
      lvl = t.levels[i];
      if (lvl != btn_level[i]) begin
        // rise after a long press leaves the button idle
        if (!(btn_level[i] == 1'b0 && !btn_active[i])) begin
          btn_stamp[i]  = t.now_ms;
          btn_active[i] = 1'b1;
          if (!lvl && btn_presses[i] != bclp_pkg::COUNT_MAX)
            btn_presses[i] = btn_presses[i] + 1'b1;
        end
        btn_level[i] = lvl;
      end else if (btn_active[i]) begin
        held = t.now_ms - btn_stamp[i];
        fire = lvl ? (held > short_limit) : (held > long_limit);
        if (fire) begin
          if (have_ev)
            due_events.push_back(held_ev);
          held_ev.button_index = 3'(i);
          held_ev.action       = lvl ? bclp_pkg::ACT_SHORT : bclp_pkg::ACT_LONG;
          held_ev.press_count  = btn_presses[i];
          held_ev.last_event   = 1'b0;
          have_ev        = 1;
          btn_presses[i] = '0;
          btn_active[i]  = 1'b0;
        end
      end
    end
    if (have_ev) begin
      held_ev.last_event = 1'b1;
      due_events.push_back(held_ev);
    end
  endfunction

  // driver, also keeps the predicted state in step with the block
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      long_limit  = bclp_pkg::LONG_RESET;
      short_limit = bclp_pkg::SHORT_RESET;
      btn_level   = '1;
      btn_active  = '0;
      for (int i = 0; i < bclp_pkg::LEVEL_BITS; i++) begin
        btn_stamp[i]   = '0;
        btn_presses[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bclp_pkg::REG_LONG:  long_limit  = cfg_data;
          bclp_pkg::REG_SHORT: short_limit = cfg_data;
          default: ;
        endcase
      end
      if (tick_valid && tick_if.ready) begin
        classify_tick(tick_data);
        ticks_accepted++;
      end
      if (!tick_valid || tick_if.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tick_valid <= 1'b1;
          tick_data  <= pending_ticks.pop_front();
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      event_ready <= 1'b0;
    end else if (hold_left != 0) begin
      event_ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      event_ready <= 1'b0;
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else begin
      event_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_field(input string name, input int unsigned want,
                            input int unsigned got);
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bclp_pkg::out_item_t want;
    bclp_pkg::out_item_t got;
    if (!rst && event_if.valid && event_ready) begin
      got = event_if.payload;
      if (due_events.size() == 0) begin
        $display("%0t: event expected none actual button %0d action %0d count %0d last %0d",
                 $time, got.button_index, got.action, got.press_count, got.last_event);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        if (got.button_index != want.button_index)
          flag_field("button_index", want.button_index, got.button_index);
        if (got.action != want.action)
          flag_field("action", want.action, got.action);
        if (got.press_count != want.press_count)
          flag_field("press_count", want.press_count, got.press_count);
        if (got.last_event != want.last_event)
          flag_field("last_event", want.last_event, got.last_event);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && tick_if.ready) || (event_if.valid && event_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_tick(input logic [bclp_pkg::TIME_W-1:0] now,
                            input logic [bclp_pkg::LEVEL_BITS-1:0] lv);
    bclp_pkg::in_item_t t;
    t.now_ms = now;
    t.levels = lv;
    pending_ticks.push_back(t);
    ticks_queued++;
    gen_now    = now;
    gen_levels = lv;
  endtask

  task automatic drain();
    while (ticks_accepted != ticks_queued || due_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [bclp_pkg::LIMIT_W-1:0] lng,
                            input logic [bclp_pkg::LIMIT_W-1:0] shrt);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bclp_pkg::REG_LONG;
    cfg_data  <= lng;
    @(posedge clk);
    cfg_index <= bclp_pkg::REG_SHORT;
    cfg_data  <= shrt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly sparse level flips with small time steps, some pure noise
  task automatic random_ticks(input int n, input int max_step, input int noise_pct);
    logic [bclp_pkg::LEVEL_BITS-1:0] flips;
    repeat (n) begin
      if ($urandom_range(99) < noise_pct) begin
        queue_tick($urandom, 8'($urandom));
      end else begin
        flips = 8'($urandom & $urandom & $urandom);
        queue_tick(gen_now + $urandom_range(max_step), gen_levels ^ flips);
      end
    end
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 73;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset limits: 3000 long, 300 short
    queue_tick(32'd100, 8'hFF);
    queue_tick(32'd200, 8'hFE);
    queue_tick(32'd300, 8'hFF);
    queue_tick(32'd600, 8'hFF);
    queue_tick(32'd601, 8'hFF);
    queue_tick(32'd1000, 8'hFD);
    queue_tick(32'd1100, 8'hFF);
    queue_tick(32'd1200, 8'hFD);
    queue_tick(32'd1300, 8'hFF);
    queue_tick(32'd1601, 8'hFF);
    queue_tick(32'd2000, 8'hFB);
    queue_tick(32'd5000, 8'hFB);
    queue_tick(32'd5001, 8'hFB);
    queue_tick(32'd5100, 8'hFF);
    queue_tick(32'd5500, 8'hFF);
    queue_tick(32'd7000, 8'h00);
    queue_tick(32'd7010, 8'hFF);
    queue_tick(32'd7400, 8'hFF);
    queue_tick(32'hFFFF_FF00, 8'hEF);
    queue_tick(32'hFFFF_FFFF, 8'hFF);
    queue_tick(32'h0000_012C, 8'hFF);
    queue_tick(32'h0000_1000, 8'hDF);
    queue_tick(32'h0000_1010, 8'hFF);
    queue_tick(32'h0000_1020, 8'hDF);
    queue_tick(32'h0000_1BD9, 8'hDF);
    drain();

    set_limits(16'd20, 16'd10);
    random_ticks(40, 15, 10);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 16;
    set_limits(16'd0, 16'd0);
    random_ticks(20, 3, 10);
    drain();

    // multi-press counts on every button, then both limits at their top
    set_limits(16'hFFFF, 16'hFFFF);
    queue_tick(gen_now + 1, 8'hFF);
    for (int k = 0; k < 16; k++)
      queue_tick(gen_now + $urandom_range(50), (k % 2 == 0) ? 8'h00 : 8'hFF);
    queue_tick(gen_now + 32'd65535, 8'hFF);
    queue_tick(gen_now + 32'd1, 8'hFF);
    queue_tick(gen_now + 32'd5, 8'h00);
    queue_tick(gen_now + 32'd65535, 8'h00);
    queue_tick(gen_now + 32'd1, 8'h00);
    queue_tick(gen_now + 32'd9, 8'hFF);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(16'd8, 16'd4);
    hold_requests++;
    random_ticks(30, 12, 10);
    drain();

    set_limits(16'($urandom_range(40)), 16'($urandom_range(40)));
    random_ticks(20, 30, 15);
    drain();

    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bclp_pkg.sv
hw/rtl/bclp_stream_if.sv
hw/rtl/button_click_long_press_classifier.sv
tb/tb.sv
